>>> rtl/core/dce_pkg.sv
// Shared widths, function codes and register indexes of the density clustering engine.
package dce_pkg;

   localparam int FUNC_W      = 1;
   localparam int PIDX_W      = 6;
   localparam int CFIELD_W    = 16;
   localparam int CLUS_W      = 7;
   localparam int EPS_W       = 35;
   localparam int MINPTS_W    = 7;
   localparam int PCOUNT_W    = 7;
   localparam int DIMS_W      = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 35;

   localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_RUN  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_EPS_SQUARED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PTS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMS_IN_USE = 2'd3;

   typedef logic signed [CFIELD_W-1:0] coord_field_type;

endpackage

>>> rtl/core/dce_if.sv
// Request and response channel interfaces of the density clustering engine.
interface dce_req_if
   import dce_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [FUNC_W-1:0]     func;
   logic [PIDX_W-1:0]     point_index;
   coord_field_type       coord_0;
   coord_field_type       coord_1;
   coord_field_type       coord_2;
   coord_field_type       coord_3;

   modport source (output valid, func, point_index, coord_0, coord_1, coord_2, coord_3,
                   input ready);
   modport sink   (input valid, func, point_index, coord_0, coord_1, coord_2, coord_3,
                   output ready);
endinterface

interface dce_rsp_if
   import dce_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [PIDX_W-1:0]     label_index;
   logic [CLUS_W-1:0]     cluster_id;
   logic                  is_noise;
   logic [CLUS_W-1:0]     cluster_total;
   logic                  is_last;

   modport source (output valid, label_index, cluster_id, is_noise, cluster_total, is_last,
                   input ready);
   modport sink   (input valid, label_index, cluster_id, is_noise, cluster_total, is_last,
                   output ready);
endinterface

>>> rtl/core/dce_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module dce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/density_clustering_engine.sv
// DBSCAN clustering engine: point store, distance sweep pipeline, queue sequencer, label output.
//
// Load items write one point into the coordinate memory. A run item clusters the first
// point_count points (clamped to 1..MAX_POINTS) and then returns one label item per point, in
// index order. During a run the block takes no request. The run time is set by the distance
// sweep: every neighbour count reads all n points from the coordinate memory, one per cycle,
// through a five-stage difference, square, sum and compare pipeline. Each point is swept once
// when it is visited or reached from the queue, and a core point adds one more pass over all n
// points that pushes its new neighbours into the expansion queue. There is no clearing pass:
// the per-point marks live in flip-flops and are cleared in the cycle the run item is accepted.
module density_clustering_engine
   import dce_pkg::*;
#(
   parameter int MAX_POINTS  = 64,
   parameter int MAX_DIMS    = 4,
   parameter int COORD_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   dce_req_if.sink                 req_ch,
   dce_rsp_if.source               rsp_ch,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W   = $clog2(MAX_POINTS);
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int PT_W    = MAX_DIMS * COORD_WIDTH;
   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int SQ_W    = 2 * COORD_WIDTH + 1;
   localparam int SUM_W   = SQ_W + 2;
   localparam int CMP_W   = (SUM_W > EPS_W) ? SUM_W : EPS_W;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_VISIT    = 4'd1;
   localparam logic [3:0] ST_CNT_LOAD = 4'd2;
   localparam logic [3:0] ST_SWEEP    = 4'd3;
   localparam logic [3:0] ST_DECIDE   = 4'd4;
   localparam logic [3:0] ST_ENQ      = 4'd5;
   localparam logic [3:0] ST_POP      = 4'd6;
   localparam logic [3:0] ST_POP_WAIT = 4'd7;
   localparam logic [3:0] ST_EMIT_RD  = 4'd8;
   localparam logic [3:0] ST_EMIT_WR  = 4'd9;

   // Configuration registers.
   logic [EPS_W-1:0]    eps_ff;
   logic [MINPTS_W-1:0] minpts_ff;
   logic [PCOUNT_W-1:0] pcount_ff;
   logic [DIMS_W-1:0]   dims_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff    <= '0;
         minpts_ff <= MINPTS_W'(4);
         pcount_ff <= PCOUNT_W'(64);
         dims_ff   <= DIMS_W'(2);
      end else if (csr_we) begin
         case (csr_index)
            CSR_EPS_SQUARED: eps_ff    <= csr_wdata[EPS_W-1:0];
            CSR_MIN_PTS:     minpts_ff <= csr_wdata[MINPTS_W-1:0];
            CSR_POINT_COUNT: pcount_ff <= csr_wdata[PCOUNT_W-1:0];
            CSR_DIMS_IN_USE: dims_ff   <= csr_wdata[DIMS_W-1:0];
            default: ;
         endcase
      end
   end

   logic [CNT_W-1:0]  n_eff;
   logic [DIMS_W-1:0] dims_eff;

   always_comb begin
      if (pcount_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (int'(pcount_ff) > MAX_POINTS) begin
         n_eff = CNT_W'(MAX_POINTS);
      end else begin
         n_eff = CNT_W'(pcount_ff);
      end
      if (dims_ff == '0) begin
         dims_eff = DIMS_W'(1);
      end else if (int'(dims_ff) > MAX_DIMS) begin
         dims_eff = DIMS_W'(MAX_DIMS);
      end else begin
         dims_eff = dims_ff;
      end
   end

   // Sequencer registers.
   logic [3:0]            state_ff, state_in;
   logic [CNT_W-1:0]      p_ff, p_in;
   logic [CNT_W-1:0]      qi_ff, qi_in;
   logic [CNT_W-1:0]      eq_ff, eq_in;
   logic [CNT_W-1:0]      e_ff, e_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      tail_ff, tail_in;
   logic [IDX_W-1:0]      cur_ff, cur_in;
   logic                  seed_ff, seed_in;
   logic [CLUS_W-1:0]     clus_ff, clus_in;
   logic [MAX_POINTS-1:0] lab_valid_ff, lab_valid_in;
   logic [MAX_POINTS-1:0] noise_ff, noise_in;
   logic [MAX_POINTS-1:0] queued_ff, queued_in;
   logic [MAX_POINTS-1:0] nbr_ff, nbr_in;
   logic [PT_W-1:0]       pc_ff, pc_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIDX_W-1:0]     rsp_idx_ff, rsp_idx_in;
   logic [CLUS_W-1:0]     rsp_id_ff, rsp_id_in;
   logic                  rsp_noise_ff, rsp_noise_in;
   logic [CLUS_W-1:0]     rsp_total_ff, rsp_total_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic                  crd_en;
   logic [IDX_W-1:0]      crd_addr;
   logic [PT_W-1:0]       crd_data;
   logic                  cwr_en;
   logic [PT_W-1:0]       cwr_data;
   logic                  lwr_en;
   logic [IDX_W-1:0]      lwr_addr;
   logic [CLUS_W-1:0]     lwr_data;
   logic                  lrd_en;
   logic [CLUS_W-1:0]     lrd_data;
   logic                  qwr_en;
   logic [IDX_W-1:0]      qwr_data;
   logic                  qrd_en;
   logic [IDX_W-1:0]      qrd_data;

   // Distance pipeline.
   logic                       issue;
   logic                       v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic [IDX_W-1:0]           q0_ff, q1_ff, q2_ff, q3_ff, q4_ff;
   logic signed [DIFF_W-1:0]   diff_ff [MAX_DIMS];
   logic [SQ_W-1:0]            sq_ff [MAX_DIMS];
   logic [SUM_W-1:0]           sum_ff;
   logic                       hit_ff;
   logic signed [PROD_W-1:0]   prod [MAX_DIMS];
   logic [SUM_W-1:0]           sum_c;
   logic                       pipe_busy;

   coord_field_type            cin [4];

   assign cin[0] = req_ch.coord_0;
   assign cin[1] = req_ch.coord_1;
   assign cin[2] = req_ch.coord_2;
   assign cin[3] = req_ch.coord_3;

   always_comb begin
      cwr_data = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         cwr_data[d*COORD_WIDTH +: COORD_WIDTH] = cin[d][COORD_WIDTH-1:0];
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign cwr_en = req_ch.valid && req_ch.ready && (req_ch.func == FUNC_LOAD)
                   && (int'(req_ch.point_index) < MAX_POINTS);

   assign pipe_busy = v0_ff || v1_ff || v2_ff || v3_ff || v4_ff;
   assign issue     = (state_ff == ST_SWEEP) && (qi_ff != n_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v0_ff <= issue;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_comb begin
      sum_c = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         prod[d] = diff_ff[d] * diff_ff[d];
         sum_c   = sum_c + SUM_W'(sq_ff[d]);
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= qi_ff[IDX_W-1:0];
      q1_ff <= q0_ff;
      q2_ff <= q1_ff;
      q3_ff <= q2_ff;
      q4_ff <= q3_ff;
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (d < int'(dims_eff)) begin
            diff_ff[d] <= DIFF_W'(signed'(pc_ff[d*COORD_WIDTH +: COORD_WIDTH]))
                        - DIFF_W'(signed'(crd_data[d*COORD_WIDTH +: COORD_WIDTH]));
         end else begin
            diff_ff[d] <= '0;
         end
         sq_ff[d] <= prod[d][SQ_W-1:0];
      end
      sum_ff <= sum_c;
      hit_ff <= CMP_W'(sum_ff) < CMP_W'(eps_ff);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      qi_in        = qi_ff;
      eq_in        = eq_ff;
      e_in         = e_ff;
      cnt_in       = cnt_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      seed_in      = seed_ff;
      clus_in      = clus_ff;
      lab_valid_in = lab_valid_ff;
      noise_in     = noise_ff;
      queued_in    = queued_ff;
      nbr_in       = nbr_ff;
      pc_in        = pc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_noise_in = rsp_noise_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in  = rsp_last_ff;

      crd_en   = issue;
      crd_addr = qi_ff[IDX_W-1:0];
      lwr_en   = 1'b0;
      lwr_addr = cur_ff;
      lwr_data = clus_ff;
      lrd_en   = 1'b0;
      qwr_en   = 1'b0;
      qrd_en   = 1'b0;

      if (issue) begin
         qi_in = qi_ff + CNT_W'(1);
      end
      if (v4_ff && hit_ff) begin
         cnt_in        = cnt_ff + CNT_W'(1);
         nbr_in[q4_ff] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid && req_ch.func == FUNC_RUN) begin
               lab_valid_in = '0;
               noise_in     = '0;
               queued_in    = '0;
               clus_in      = '0;
               p_in         = '0;
               state_in     = ST_VISIT;
            end
         end
         ST_VISIT: begin
            if (p_ff == n_eff) begin
               e_in     = '0;
               state_in = ST_EMIT_RD;
            end else if (lab_valid_ff[p_ff[IDX_W-1:0]] || noise_ff[p_ff[IDX_W-1:0]]) begin
               p_in = p_ff + CNT_W'(1);
            end else begin
               cur_in   = p_ff[IDX_W-1:0];
               seed_in  = 1'b1;
               crd_en   = 1'b1;
               crd_addr = p_ff[IDX_W-1:0];
               state_in = ST_CNT_LOAD;
            end
         end
         ST_CNT_LOAD: begin
            pc_in    = crd_data;
            qi_in    = '0;
            cnt_in   = '0;
            nbr_in   = '0;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (!issue && !pipe_busy) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (MINPTS_W'(cnt_ff) >= minpts_ff) begin
               eq_in    = '0;
               state_in = ST_ENQ;
               if (seed_ff) begin
                  // A new cluster opens at this seed with an empty queue.
                  clus_in              = clus_ff + CLUS_W'(1);
                  lwr_en               = 1'b1;
                  lwr_data             = clus_ff + CLUS_W'(1);
                  lab_valid_in[cur_ff] = 1'b1;
                  head_in              = '0;
                  tail_in              = '0;
               end
            end else if (seed_ff) begin
               noise_in[cur_ff] = 1'b1;
               p_in             = p_ff + CNT_W'(1);
               state_in         = ST_VISIT;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_ENQ: begin
            if (eq_ff == n_eff) begin
               state_in = ST_POP;
            end else begin
               if (nbr_ff[eq_ff[IDX_W-1:0]] && !queued_ff[eq_ff[IDX_W-1:0]]) begin
                  queued_in[eq_ff[IDX_W-1:0]] = 1'b1;
                  qwr_en  = 1'b1;
                  tail_in = tail_ff + CNT_W'(1);
               end
               eq_in = eq_ff + CNT_W'(1);
            end
         end
         ST_POP: begin
            if (head_ff != tail_ff) begin
               qrd_en   = 1'b1;
               head_in  = head_ff + CNT_W'(1);
               state_in = ST_POP_WAIT;
            end else begin
               p_in     = p_ff + CNT_W'(1);
               state_in = ST_VISIT;
            end
         end
         ST_POP_WAIT: begin
            lwr_addr = qrd_data;
            if (noise_ff[qrd_data]) begin
               // A noise point reached from a core point becomes a border member.
               noise_in[qrd_data]     = 1'b0;
               lwr_en                 = 1'b1;
               lab_valid_in[qrd_data] = 1'b1;
               state_in               = ST_POP;
            end else if (!lab_valid_ff[qrd_data]) begin
               lwr_en                 = 1'b1;
               lab_valid_in[qrd_data] = 1'b1;
               cur_in                 = qrd_data;
               seed_in                = 1'b0;
               crd_en                 = 1'b1;
               crd_addr               = qrd_data;
               state_in               = ST_CNT_LOAD;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_EMIT_RD: begin
            lrd_en   = 1'b1;
            state_in = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = PIDX_W'(e_ff[IDX_W-1:0]);
               rsp_noise_in = noise_ff[e_ff[IDX_W-1:0]];
               rsp_id_in    = (noise_ff[e_ff[IDX_W-1:0]] || !lab_valid_ff[e_ff[IDX_W-1:0]])
                              ? '0 : lrd_data;
               rsp_total_in = clus_ff;
               rsp_last_in  = (e_ff + CNT_W'(1) == n_eff);
               if (e_ff + CNT_W'(1) == n_eff) begin
                  state_in = ST_IDLE;
               end else begin
                  e_in     = e_ff + CNT_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lab_valid_ff <= '0;
         noise_ff     <= '0;
         queued_ff    <= '0;
         clus_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lab_valid_ff <= lab_valid_in;
         noise_ff     <= noise_in;
         queued_ff    <= queued_in;
         clus_ff      <= clus_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      qi_ff        <= qi_in;
      eq_ff        <= eq_in;
      e_ff         <= e_in;
      cnt_ff       <= cnt_in;
      head_ff      <= head_in;
      tail_ff      <= tail_in;
      cur_ff       <= cur_in;
      seed_ff      <= seed_in;
      nbr_ff       <= nbr_in;
      pc_ff        <= pc_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_noise_ff <= rsp_noise_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.label_index   = rsp_idx_ff;
   assign rsp_ch.cluster_id    = rsp_id_ff;
   assign rsp_ch.is_noise      = rsp_noise_ff;
   assign rsp_ch.cluster_total = rsp_total_ff;
   assign rsp_ch.is_last       = rsp_last_ff;

   dce_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_coord_ram (
      .clock   (clock),
      .wr_en   (cwr_en),
      .wr_addr (req_ch.point_index[IDX_W-1:0]),
      .wr_data (cwr_data),
      .rd_en   (crd_en),
      .rd_addr (crd_addr),
      .rd_data (crd_data)
   );

   dce_ram #(.WIDTH(CLUS_W), .DEPTH(MAX_POINTS)) u_label_ram (
      .clock   (clock),
      .wr_en   (lwr_en),
      .wr_addr (lwr_addr),
      .wr_data (lwr_data),
      .rd_en   (lrd_en),
      .rd_addr (e_ff[IDX_W-1:0]),
      .rd_data (lrd_data)
   );

   dce_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_queue_ram (
      .clock   (clock),
      .wr_en   (qwr_en),
      .wr_addr (tail_ff[IDX_W-1:0]),
      .wr_data (eq_ff[IDX_W-1:0]),
      .rd_en   (qrd_en),
      .rd_addr (head_ff[IDX_W-1:0]),
      .rd_data (qrd_data)
   );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench of the density clustering engine: loads, runs and label checks.
module tb_top;
   import dce_pkg::*;

   localparam int NPTS       = 64;
   localparam int NDIMS      = 4;
   localparam int CYCLE_CAP  = 3000000;
   localparam int SEGMENTS   = 36;

   typedef struct {
      logic [FUNC_W-1:0]  func;
      logic [PIDX_W-1:0]  point_index;
      coord_field_type    crd[NDIMS];
   } point_item_type;

   typedef struct {
      logic [PIDX_W-1:0]  label_index;
      logic [CLUS_W-1:0]  cluster_id;
      logic               is_noise;
      logic [CLUS_W-1:0]  cluster_total;
      logic               is_last;
   } label_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dce_req_if req_bus ();
   dce_rsp_if rsp_bus ();

   density_clustering_engine DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus.sink),
      .rsp_ch    (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the block's registers and point memory.
   logic [EPS_W-1:0]    eps_sq;
   logic [MINPTS_W-1:0] core_min;
   logic [PCOUNT_W-1:0] used_points;
   logic [DIMS_W-1:0]   used_dims;
   coord_field_type     point_store[NPTS][NDIMS];

   point_item_type pending_items[$];
   label_type      labels_due[$];
   point_item_type drv_item;
   coord_field_type centers[4][NDIMS];

   int send_pct;
   int recv_pct;
   int fail_count;
   int labels_checked;
   int runs_done;
   int cycles;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic bit close_pair(int p, int q, int dims);
      longint sum;
      int diff;
      sum = 0;
      for (int d = 0; d < dims; d++) begin
         diff = int'(point_store[p][d]) - int'(point_store[q][d]);
         sum += longint'(diff) * longint'(diff);
      end
      return sum < longint'(eps_sq);
   endfunction

   function automatic int count_close(int p, int n, int dims);
      int c;
      c = 0;
      for (int q = 0; q < n; q++)
         if (close_pair(p, q, dims)) c++;
      return c;
   endfunction

   function automatic void push_close(int p, int n, int dims, ref bit queued[NPTS],
                                      ref int fifo[NPTS], ref int tail);
      for (int q = 0; q < n; q++) begin
         if (!queued[q] && close_pair(p, q, dims)) begin
            queued[q] = 1'b1;
            fifo[tail % NPTS] = q;
            tail++;
         end
      end
   endfunction

   // Clusters the first n points and queues one expected label per point.
   function automatic void predict_labels();
      int n, dims, head, tail, pn, clusters;
      bit [CLUS_W-1:0] lab[NPTS];
      bit noise[NPTS];
      bit queued[NPTS];
      int fifo[NPTS];
      label_type r;
      n = (used_points < 1) ? 1 : (used_points > NPTS) ? NPTS : int'(used_points);
      dims = (used_dims < 1) ? 1 : (used_dims > NDIMS) ? NDIMS : int'(used_dims);
      clusters = 0;
      for (int p = 0; p < NPTS; p++) begin
         lab[p] = '0;
         noise[p] = 1'b0;
         queued[p] = 1'b0;
         fifo[p] = 0;
      end
      for (int p = 0; p < n; p++) begin
         if (lab[p] != 0 || noise[p]) continue;
         if (count_close(p, n, dims) < int'(core_min)) begin
            noise[p] = 1'b1;
         end else begin
            clusters++;
            head = 0;
            tail = 0;
            lab[p] = clusters[CLUS_W-1:0];
            push_close(p, n, dims, queued, fifo, tail);
            while (head < tail && head < NPTS) begin
               pn = fifo[head % NPTS];
               head++;
               if (noise[pn]) begin
                  noise[pn] = 1'b0;
                  lab[pn] = clusters[CLUS_W-1:0];
               end else if (lab[pn] == 0) begin
                  lab[pn] = clusters[CLUS_W-1:0];
                  if (count_close(pn, n, dims) >= int'(core_min))
                     push_close(pn, n, dims, queued, fifo, tail);
               end
            end
         end
      end
      for (int p = 0; p < n; p++) begin
         r.label_index = p[PIDX_W-1:0];
         r.cluster_id = noise[p] ? '0 : lab[p];
         r.is_noise = noise[p];
         r.cluster_total = clusters[CLUS_W-1:0];
         r.is_last = (p + 1 == n);
         labels_due = {labels_due, r};
      end
   endfunction

   function automatic void apply_item(point_item_type it);
      if (it.func == FUNC_LOAD) begin
         for (int d = 0; d < NDIMS; d++)
            point_store[it.point_index][d] = it.crd[d];
      end else begin
         runs_done++;
         predict_labels();
      end
   endfunction

   // Driver: the next item goes out once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            apply_item(drv_item);
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_pct) begin
               drv_item = pending_items.pop_front();
               req_bus.func <= drv_item.func;
               req_bus.point_index <= drv_item.point_index;
               req_bus.coord_0 <= drv_item.crd[0];
               req_bus.coord_1 <= drv_item.crd[1];
               req_bus.coord_2 <= drv_item.crd[2];
               req_bus.coord_3 <= drv_item.crd[3];
               req_bus.valid <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: labels are checked in order against the prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (labels_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected label item, index %0d cluster %0d", $time,
                        rsp_bus.label_index, rsp_bus.cluster_id);
            end else begin
               label_type e;
               e = labels_due.pop_front();
               labels_checked++;
               if (e.label_index !== rsp_bus.label_index ||
                   e.cluster_id !== rsp_bus.cluster_id ||
                   e.is_noise !== rsp_bus.is_noise ||
                   e.cluster_total !== rsp_bus.cluster_total ||
                   e.is_last !== rsp_bus.is_last)
               begin
                  fail_count++;
                  $display("%0t: label mismatch, expected idx %0d id %0d noise %0b %s",
                           $time, e.label_index, e.cluster_id, e.is_noise,
                           $sformatf("total %0d last %0b", e.cluster_total, e.is_last));
                  $display("%0t:                   actual idx %0d id %0d noise %0b %s",
                           $time, rsp_bus.label_index, rsp_bus.cluster_id,
                           rsp_bus.is_noise,
                           $sformatf("total %0d last %0b", rsp_bus.cluster_total,
                                     rsp_bus.is_last));
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("density_clustering_engine test failed");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_EPS_SQUARED: eps_sq = value[EPS_W-1:0];
         CSR_MIN_PTS:     core_min = value[MINPTS_W-1:0];
         CSR_POINT_COUNT: used_points = value[PCOUNT_W-1:0];
         CSR_DIMS_IN_USE: used_dims = value[DIMS_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_regs(longint eps, int mn, int cnt, int dims);
      write_reg(CSR_EPS_SQUARED, eps[CSR_DATA_W-1:0]);
      write_reg(CSR_MIN_PTS, CSR_DATA_W'(mn));
      write_reg(CSR_POINT_COUNT, CSR_DATA_W'(cnt));
      write_reg(CSR_DIMS_IN_USE, CSR_DATA_W'(dims));
   endtask

   // Loads are short, so the spare wait at the end covers the last one.
   task automatic wait_drained();
      while (pending_items.size() > 0 || req_bus.valid || labels_due.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic queue_load(int idx, bit stray);
      point_item_type it;
      int k;
      it.func = FUNC_LOAD;
      it.point_index = idx[PIDX_W-1:0];
      k = $urandom_range(3);
      for (int d = 0; d < NDIMS; d++)
         it.crd[d] = stray ? coord_field_type'($urandom)
                           : centers[k][d] + coord_field_type'($urandom_range(600)) - 16'sd300;
      pending_items = {pending_items, it};
   endtask

   task automatic queue_run();
      point_item_type it;
      it.func = FUNC_RUN;
      it.point_index = PIDX_W'($urandom);
      for (int d = 0; d < NDIMS; d++) it.crd[d] = coord_field_type'($urandom);
      pending_items = {pending_items, it};
   endtask

   task automatic new_centers();
      for (int k = 0; k < 4; k++)
         for (int d = 0; d < NDIMS; d++) centers[k][d] = coord_field_type'($urandom);
   endtask

   initial begin
      point_item_type it;
      longint eps;
      int mn, cnt, dims, nloads;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_LOAD;
      req_bus.point_index = '0;
      req_bus.coord_0 = '0;
      req_bus.coord_1 = '0;
      req_bus.coord_2 = '0;
      req_bus.coord_3 = '0;
      rsp_bus.ready = 1'b0;
      eps_sq = '0;
      core_min = 7'd4;
      used_points = 7'd64;
      used_dims = 3'd2;
      send_pct = 0;
      recv_pct = 0;
      fail_count = 0;
      labels_checked = 0;
      runs_done = 0;
      cycles = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Every point is written before any run reads it.
      new_centers();
      for (int i = 0; i < NPTS; i++) queue_load(i, ($urandom_range(5) == 0));
      wait_drained();

      // Directed: coordinate extremes, saturated registers, zero radius, unreachable threshold.
      it.func = FUNC_LOAD;
      it.point_index = 6'd0;
      for (int d = 0; d < NDIMS; d++) it.crd[d] = 16'sh8000;
      pending_items = {pending_items, it};
      it.point_index = 6'd1;
      for (int d = 0; d < NDIMS; d++) it.crd[d] = 16'sh7fff;
      pending_items = {pending_items, it};
      wait_drained();
      set_regs(64'h7_ffff_ffff, 0, 127, 7);
      queue_run();
      wait_drained();
      set_regs(0, 1, 0, 0);
      queue_run();
      wait_drained();
      set_regs(0, 0, 64, 4);
      queue_run();
      wait_drained();
      set_regs(64'h7_ffff_ffff, 127, 10, 4);
      queue_run();
      wait_drained();
      set_regs(64'h7_ffff_ffff, 64, 64, 1);
      queue_run();
      wait_drained();
      set_regs(17179344900, 2, 2, 4);
      queue_run();
      wait_drained();
      set_regs(17179344901, 2, 2, 4);
      queue_run();
      queue_run();
      wait_drained();

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg % 4)
            0: begin send_pct = 0;  recv_pct = 0;  end
            1: begin send_pct = 83; recv_pct = 0;  end
            2: begin send_pct = 0;  recv_pct = 83; end
            default: begin send_pct = 9; recv_pct = 9; end
         endcase
         dims = $urandom_range(1, 4);
         if ($urandom_range(9) == 0) dims = $urandom_range(7);
         case ($urandom_range(9))
            0: eps = 0;
            1: eps = 64'h7_ffff_ffff;
            2: eps = longint'($urandom) << 3;
            default: eps = longint'($urandom_range(40, 700)) ** 2 * dims;
         endcase
         mn = $urandom_range(1, 6);
         if ($urandom_range(7) == 0) mn = ($urandom_range(1)) ? 0 : $urandom_range(7, 127);
         cnt = ($urandom_range(8) == 0) ? 64 : $urandom_range(3, 16);
         if ($urandom_range(11) == 0) cnt = ($urandom_range(1)) ? 0 : 127;
         set_regs(eps, mn, cnt, dims);
         if ($urandom_range(2) == 0) new_centers();
         nloads = $urandom_range(6, 12);
         for (int i = 0; i < nloads; i++)
            queue_load(($urandom_range(4) == 0) ? $urandom_range(63)
                                                 : $urandom_range(((cnt < 1) ? 1 : (cnt > 64)
                                                                   ? 64 : cnt) - 1),
                       ($urandom_range(7) == 0));
         queue_run();
         if ($urandom_range(5) == 0) queue_run();
         wait_drained();
      end

      repeat (50) @(posedge clock);
      $display("Checked %0d labels from %0d clustering runs under four idle patterns.",
               labels_checked, runs_done);
      if (fail_count == 0 && labels_due.size() == 0) begin
         $display("density_clustering_engine test passed");
      end else begin
         $display("density_clustering_engine test failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/dce_pkg.sv
rtl/core/dce_if.sv
rtl/core/dce_ram.sv
rtl/core/density_clustering_engine.sv
tb/tb_top.sv
